@@ rtl/core/assert_macros.svh @@
// Assertion helpers shared by the RTL.
// Each check is sampled on the rising clock edge and disabled while reset is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Property must hold on every sampled edge out of reset
`define ASSERT_PROP(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("assertion failed");

// Condition must never be seen out of reset
`define ASSERT_NEVER(lbl, clk, rst_n, cond) \
    `ASSERT_PROP(lbl, clk, rst_n, !(cond))

`else

`define ASSERT_PROP(lbl, clk, rst_n, prop)
`define ASSERT_NEVER(lbl, clk, rst_n, cond)

`endif

`endif

@@ rtl/core/hrp_pkg.sv @@
`timescale 1ns / 1ps

package hrp_pkg;

    // Result kinds
    localparam logic [1:0] KIND_DATA  = 2'd0;
    localparam logic [1:0] KIND_OK    = 2'd1;
    localparam logic [1:0] KIND_EOF   = 2'd2;
    localparam logic [1:0] KIND_ERROR = 2'd3;

    // Error codes
    localparam logic [2:0] ERR_NONE      = 3'd0;
    localparam logic [2:0] ERR_START     = 3'd1;
    localparam logic [2:0] ERR_CHECKSUM  = 3'd2;
    localparam logic [2:0] ERR_TYPE      = 3'd3;
    localparam logic [2:0] ERR_NOT_HEX   = 3'd4;

    // Record types
    localparam logic [7:0] REC_DATA    = 8'h00;
    localparam logic [7:0] REC_EOF     = 8'h01;
    localparam logic [7:0] REC_SEGMENT = 8'h02;

    // Characters
    localparam logic [7:0] CHAR_COLON = 8'h3A;

    localparam int ADDR_W = 21;

    // Classified input character
    typedef struct packed {
        logic       is_space;
        logic       is_colon;
        logic       is_hex;
        logic [3:0] nibble;
    } t_char_class;

endpackage

@@ rtl/core/hrp_if.sv @@
`timescale 1ns / 1ps

// Character channel
interface hrp_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] char_in;

    modport source (output valid, output char_in, input ready);
    modport sink   (input valid, input char_in, output ready);
endinterface

// Result channel
interface hrp_out_if;
    logic        valid;
    logic        ready;
    logic [1:0]  kind;
    logic [20:0] byte_address;
    logic [7:0]  byte_value;
    logic [2:0]  error_code;

    modport source (output valid, output kind, output byte_address,
                    output byte_value, output error_code, input ready);
    modport sink   (input valid, input kind, input byte_address,
                    input byte_value, input error_code, output ready);
endinterface

@@ rtl/core/hrp_char_decode.sv @@
`timescale 1ns / 1ps

// Classifies one ASCII character: whitespace, record mark, hex digit value.
module hrp_char_decode (
    input  logic [7:0]           i_char,
    output hrp_pkg::t_char_class o_class
);

    always_comb begin
        o_class          = '0;
        o_class.is_space = i_char inside {8'h20, [8'h09:8'h0D]};
        o_class.is_colon = (i_char == hrp_pkg::CHAR_COLON);
        case (i_char) inside
            [8'h30:8'h39]: begin
                o_class.is_hex = 1'b1;
                o_class.nibble = i_char[3:0];
            end
            [8'h41:8'h46], [8'h61:8'h66]: begin
                // 'A'..'F' and 'a'..'f': low bits 1..6 map to 10..15
                o_class.is_hex = 1'b1;
                o_class.nibble = i_char[3:0] + 4'd9;
            end
            default: begin
                o_class.is_hex = 1'b0;
                o_class.nibble = 4'd0;
            end
        endcase
    end

endmodule

@@ rtl/core/hex_record_parser.sv @@
`timescale 1ns / 1ps
`include "assert_macros.svh"

// Intel HEX record parser.
// i_in carries one ASCII character per word; o_out carries at most one result
// word per character: a tentative data byte with its absolute address, a
// record accepted status, end of file, or an error with its code.
// Whitespace produces no result. After end of file or any error, characters
// are still taken but ignored until reset.
// A taken character is classified into the input register, then parsed into the
// result register that drives o_out, once the result slot is free.
// Throughput: one character per cycle while o_out takes results; parser state is one
// register set updated by a single pass of logic per word.
// When o_out stalls, the result register holds and the input register fills;
// i_in.ready then drops until o_out takes the pending word.
// Reset (i_rst_n low, synchronous) clears both registers' valid flags and all
// parser state: segment base zero, waiting for ':'.
module hex_record_parser (
    input  logic      i_clk,
    input  logic      i_rst_n,
    hrp_in_if.sink    i_in,
    hrp_out_if.source o_out
);

    // Parser phases
    localparam logic [2:0] PH_START  = 3'd0;
    localparam logic [2:0] PH_COUNT  = 3'd1;
    localparam logic [2:0] PH_OFFSET = 3'd2;
    localparam logic [2:0] PH_TYPE   = 3'd3;
    localparam logic [2:0] PH_DATA   = 3'd4;
    localparam logic [2:0] PH_SUM    = 3'd5;

    hrp_pkg::t_char_class w_class;
    hrp_pkg::t_char_class r_class;
    logic                 r_in_vld;
    logic                 w_advance;

    logic [2:0]  r_phase, n_phase;
    logic        r_low_nibble_next, n_low_nibble_next;
    logic [3:0]  r_high_nibble, n_high_nibble;
    logic [1:0]  r_digit_idx, n_digit_idx;
    logic [7:0]  r_rec_len, n_rec_len;
    logic [7:0]  r_bytes_seen, n_bytes_seen;
    logic [15:0] r_rec_offset, n_rec_offset;
    logic [7:0]  r_rec_type, n_rec_type;
    logic [7:0]  r_sum, n_sum;
    logic [15:0] r_first_two, n_first_two;
    logic [15:0] r_seg_base, n_seg_base;
    logic        r_stopped, n_stopped;

    logic        w_res_vld;
    logic [1:0]  w_kind;
    logic [20:0] w_addr;
    logic [7:0]  w_value;
    logic [2:0]  w_err;
    logic [7:0]  w_byte;
    logic [7:0]  w_sum_b;
    logic [7:0]  w_seen_inc;

    logic        r_out_vld;
    logic [1:0]  r_kind;
    logic [20:0] r_addr;
    logic [7:0]  r_value;
    logic [2:0]  r_err;

    hrp_char_decode u_decode (
        .i_char  (i_in.char_in),
        .o_class (w_class)
    );

    // Pipeline flow: parse stage moves when the result slot is free
    assign w_advance  = !r_out_vld || o_out.ready;
    assign i_in.ready = !r_in_vld || w_advance;

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (i_in.ready) begin
            r_in_vld <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.ready && i_in.valid) begin
            r_class <= w_class;
        end
    end

    assign w_byte     = {r_high_nibble, r_class.nibble};
    assign w_sum_b    = r_sum + w_byte;
    assign w_seen_inc = r_bytes_seen + 8'd1;

    // Parse step
    always_comb begin
        n_phase           = r_phase;
        n_low_nibble_next = r_low_nibble_next;
        n_high_nibble     = r_high_nibble;
        n_digit_idx       = r_digit_idx;
        n_rec_len         = r_rec_len;
        n_bytes_seen      = r_bytes_seen;
        n_rec_offset      = r_rec_offset;
        n_rec_type        = r_rec_type;
        n_sum             = r_sum;
        n_first_two       = r_first_two;
        n_seg_base        = r_seg_base;
        n_stopped         = r_stopped;
        w_res_vld         = 1'b0;
        w_kind            = hrp_pkg::KIND_DATA;
        w_addr            = '0;
        w_value           = '0;
        w_err             = hrp_pkg::ERR_NONE;

        if (r_in_vld && w_advance && !r_stopped && !r_class.is_space) begin
            if (r_phase == PH_START) begin
                if (!r_class.is_colon) begin
                    n_stopped = 1'b1;
                    w_res_vld = 1'b1;
                    w_kind    = hrp_pkg::KIND_ERROR;
                    w_err     = hrp_pkg::ERR_START;
                end else begin
                    n_phase           = PH_COUNT;
                    n_low_nibble_next = 1'b0;
                    n_high_nibble     = '0;
                    n_digit_idx       = '0;
                    n_rec_len         = '0;
                    n_bytes_seen      = '0;
                    n_rec_offset      = '0;
                    n_rec_type        = '0;
                    n_sum             = '0;
                    n_first_two       = '0;
                end
            end else if (!r_class.is_hex) begin
                n_stopped = 1'b1;
                w_res_vld = 1'b1;
                w_kind    = hrp_pkg::KIND_ERROR;
                w_err     = hrp_pkg::ERR_NOT_HEX;
            end else if (r_phase == PH_OFFSET) begin
                // offset digits shift in; each completed byte joins the sum
                n_rec_offset = {r_rec_offset[11:0], r_class.nibble};
                if (r_digit_idx[0]) begin
                    n_sum = r_sum + {r_rec_offset[3:0], r_class.nibble};
                end
                if (r_digit_idx == 2'd3) begin
                    n_digit_idx = '0;
                    n_phase     = PH_TYPE;
                end else begin
                    n_digit_idx = r_digit_idx + 2'd1;
                end
            end else if (!r_low_nibble_next) begin
                n_high_nibble     = r_class.nibble;
                n_low_nibble_next = 1'b1;
            end else begin
                n_low_nibble_next = 1'b0;
                n_sum             = w_sum_b;
                case (r_phase)
                    PH_COUNT: begin
                        n_rec_len   = w_byte;
                        n_phase     = PH_OFFSET;
                        n_digit_idx = '0;
                    end
                    PH_TYPE: begin
                        n_rec_type = w_byte;
                        n_phase    = (r_rec_len != 8'd0) ? PH_DATA : PH_SUM;
                    end
                    PH_DATA: begin
                        if (r_bytes_seen == 8'd0) begin
                            n_first_two[15:8] = w_byte;
                        end else if (r_bytes_seen == 8'd1) begin
                            n_first_two[7:0] = w_byte;
                        end
                        if (r_rec_type == hrp_pkg::REC_DATA) begin
                            w_res_vld = 1'b1;
                            w_kind    = hrp_pkg::KIND_DATA;
                            w_addr    = 21'({r_seg_base, 4'd0}) + 21'(r_rec_offset)
                                        + 21'(r_bytes_seen);
                            w_value   = w_byte;
                        end
                        n_bytes_seen = w_seen_inc;
                        if (w_seen_inc == r_rec_len) begin
                            n_phase = PH_SUM;
                        end
                    end
                    PH_SUM: begin
                        w_res_vld = 1'b1;
                        if (w_sum_b != 8'd0) begin
                            n_stopped = 1'b1;
                            w_kind    = hrp_pkg::KIND_ERROR;
                            w_err     = hrp_pkg::ERR_CHECKSUM;
                        end else begin
                            n_phase = PH_START;
                            case (r_rec_type)
                                hrp_pkg::REC_DATA: begin
                                    w_kind = hrp_pkg::KIND_OK;
                                end
                                hrp_pkg::REC_EOF: begin
                                    n_stopped = 1'b1;
                                    w_kind    = hrp_pkg::KIND_EOF;
                                end
                                hrp_pkg::REC_SEGMENT: begin
                                    n_seg_base = r_first_two;
                                    w_kind     = hrp_pkg::KIND_OK;
                                end
                                default: begin
                                    n_stopped = 1'b1;
                                    w_kind    = hrp_pkg::KIND_ERROR;
                                    w_err     = hrp_pkg::ERR_TYPE;
                                end
                            endcase
                        end
                    end
                    default: begin
                        // undefined phase code: fall back to record start
                        n_phase = PH_START;
                    end
                endcase
            end
        end
    end

    // Parser state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase           <= PH_START;
            r_low_nibble_next <= 1'b0;
            r_high_nibble     <= '0;
            r_digit_idx       <= '0;
            r_rec_len         <= '0;
            r_bytes_seen      <= '0;
            r_rec_offset      <= '0;
            r_rec_type        <= '0;
            r_sum             <= '0;
            r_first_two       <= '0;
            r_seg_base        <= '0;
            r_stopped         <= 1'b0;
        end else begin
            r_phase           <= n_phase;
            r_low_nibble_next <= n_low_nibble_next;
            r_high_nibble     <= n_high_nibble;
            r_digit_idx       <= n_digit_idx;
            r_rec_len         <= n_rec_len;
            r_bytes_seen      <= n_bytes_seen;
            r_rec_offset      <= n_rec_offset;
            r_rec_type        <= n_rec_type;
            r_sum             <= n_sum;
            r_first_two       <= n_first_two;
            r_seg_base        <= n_seg_base;
            r_stopped         <= n_stopped;
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (w_advance) begin
            r_out_vld <= w_res_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_advance && w_res_vld) begin
            r_kind  <= w_kind;
            r_addr  <= w_addr;
            r_value <= w_value;
            r_err   <= w_err;
        end
    end

    assign o_out.valid        = r_out_vld;
    assign o_out.kind         = r_kind;
    assign o_out.byte_address = r_addr;
    assign o_out.byte_value   = r_value;
    assign o_out.error_code   = r_err;

    // Checks
    `ASSERT_PROP(a_quiet_after_stop, i_clk, i_rst_n,
        (r_stopped && !(r_out_vld && !o_out.ready)) |=> !r_out_vld)
    `ASSERT_PROP(a_error_stops, i_clk, i_rst_n,
        (r_out_vld && r_kind == hrp_pkg::KIND_ERROR) |-> r_stopped)
    `ASSERT_PROP(a_status_no_payload, i_clk, i_rst_n,
        (r_out_vld && r_kind != hrp_pkg::KIND_DATA) |-> (r_addr == '0 && r_value == '0))
    `ASSERT_NEVER(a_nibble_phase, i_clk, i_rst_n,
        r_low_nibble_next && (r_phase == PH_START || r_phase == PH_OFFSET))

endmodule

@@ dv/tb.sv @@
`timescale 1ns / 1ps

module tb;

    localparam int          ADDR_W       = hrp_pkg::ADDR_W;
    localparam int unsigned RANDOM_CHARS = 1650;
    localparam int unsigned HOLD_AT      = 300;   // char index where the sink holds off
    localparam int unsigned DRAIN_AT     = 1000;  // char index where the source drains
    localparam int unsigned LONG_HOLD    = 80;
    localparam int unsigned SETTLE       = 20;

    // One result word as seen on the output channel
    typedef struct packed {
        logic [1:0]        kind;
        logic [ADDR_W-1:0] addr;
        logic [7:0]        value;
        logic [2:0]        err;
    } t_result;

    localparam t_result NO_WORD = '0;

    // How a directed row is checked
    typedef enum logic [1:0] {CHK_PREDICT, CHK_NONE, CHK_WORD} t_row_check;

    typedef struct {
        logic [7:0] ch;
        t_row_check check;
        t_result    w;
    } t_row;

    typedef enum logic [2:0] {
        AWAIT_COLON, GET_COUNT, GET_OFFSET, GET_TYPE, GET_DATA, GET_SUM
    } t_parse_state;

    // How the stream ends; the block halts after any of these
    typedef enum logic [2:0] {
        END_EOF, END_BAD_START, END_NOT_HEX, END_BAD_SUM, END_BAD_TYPE
    } t_ending;

    logic i_clk = 1'b0;
    logic i_rst_n;

    hrp_in_if  char_ch ();
    hrp_out_if result_ch ();

    hex_record_parser uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (char_ch),
        .o_out   (result_ch)
    );

    always #1 i_clk = ~i_clk;

    initial begin
        i_rst_n = 1'b0;
        repeat (6) @(negedge i_clk);
        i_rst_n <= 1'b1;
    end

    initial begin
        #2_000_000;
        $display("DONE: errors detected");
        $finish;
    end

    // Two records: max offset with mixed-case digits, then an empty record
    t_row directed_rows [25] = '{
        '{":", CHK_PREDICT, NO_WORD},
        '{"0", CHK_PREDICT, NO_WORD},
        '{"1", CHK_PREDICT, NO_WORD},
        '{"F", CHK_PREDICT, NO_WORD},
        '{"F", CHK_PREDICT, NO_WORD},
        '{"F", CHK_PREDICT, NO_WORD},
        '{"F", CHK_PREDICT, NO_WORD},
        '{"0", CHK_PREDICT, NO_WORD},
        '{"0", CHK_PREDICT, NO_WORD},
        '{"f", CHK_PREDICT, NO_WORD},
        '{"f", CHK_WORD,    '{hrp_pkg::KIND_DATA, 21'h0FFFF, 8'hFF, hrp_pkg::ERR_NONE}},
        '{"0", CHK_PREDICT, NO_WORD},
        '{"2", CHK_WORD,    '{hrp_pkg::KIND_OK, 21'h0, 8'h00, hrp_pkg::ERR_NONE}},
        '{8'h0A, CHK_NONE,  NO_WORD},
        '{":", CHK_PREDICT, NO_WORD},
        '{"0", CHK_PREDICT, NO_WORD},
        '{"0", CHK_PREDICT, NO_WORD},
        '{"0", CHK_PREDICT, NO_WORD},
        '{"0", CHK_PREDICT, NO_WORD},
        '{"0", CHK_PREDICT, NO_WORD},
        '{"0", CHK_PREDICT, NO_WORD},
        '{"0", CHK_PREDICT, NO_WORD},
        '{"0", CHK_PREDICT, NO_WORD},
        '{"0", CHK_PREDICT, NO_WORD},
        '{"0", CHK_WORD,    '{hrp_pkg::KIND_OK, 21'h0, 8'h00, hrp_pkg::ERR_NONE}}
    };

    logic [7:0]  char_stream [$];
    t_result     expected_words [$];
    int unsigned mismatch_count = 0;
    bit          hold_request = 1'b0;

    // Note attached to the char currently offered
    t_row_check  row_check = CHK_PREDICT;
    t_result     row_word = NO_WORD;

    // Parser model state
    t_parse_state pstate = AWAIT_COLON;
    logic         nib_pending = 1'b0;
    logic [3:0]   hi_nib = '0;
    logic [1:0]   off_digits = '0;
    logic [7:0]   rec_len = '0;
    logic [7:0]   data_count = '0;
    logic [15:0]  rec_off = '0;
    logic [7:0]   rec_type = '0;
    logic [7:0]   sum_acc = '0;
    logic [15:0]  seg_bytes = '0;
    logic [15:0]  seg_base = '0;
    logic         halted = 1'b0;

    logic         parsed_has;
    t_result      parsed_word;
    t_result      want;

    // Advance the parser model by one char; has is set when a word results
    function automatic void parse_char(input logic [7:0] c, output logic has,
                                       output t_result w);
        logic [7:0] d;
        logic [7:0] b;
        has = 1'b0;
        w = NO_WORD;
        // space, tab, LF, VT, FF, CR
        if (halted || c == 8'h20 || (c >= 8'h09 && c <= 8'h0D))
            return;
        if (pstate == AWAIT_COLON) begin
            if (c != hrp_pkg::CHAR_COLON) begin
                halted = 1'b1;
                has = 1'b1;
                w.kind = hrp_pkg::KIND_ERROR;
                w.err = hrp_pkg::ERR_START;
                return;
            end
            pstate = GET_COUNT;
            nib_pending = 1'b0;
            hi_nib = '0;
            off_digits = '0;
            rec_len = '0;
            data_count = '0;
            rec_off = '0;
            rec_type = '0;
            sum_acc = '0;
            seg_bytes = '0;
            return;
        end
        if (c >= 8'h30 && c <= 8'h39) begin
            d = c - 8'h30;
        end else if (c >= 8'h41 && c <= 8'h46) begin
            d = c - 8'h37;
        end else if (c >= 8'h61 && c <= 8'h66) begin
            d = c - 8'h57;
        end else begin
            halted = 1'b1;
            has = 1'b1;
            w.kind = hrp_pkg::KIND_ERROR;
            w.err = hrp_pkg::ERR_NOT_HEX;
            return;
        end
        // offset shifts in digit by digit, summed per completed byte
        if (pstate == GET_OFFSET) begin
            rec_off = {rec_off[11:0], d[3:0]};
            if (off_digits[0])
                sum_acc = sum_acc + rec_off[7:0];
            if (off_digits == 2'd3) begin
                off_digits = '0;
                pstate = GET_TYPE;
            end else begin
                off_digits = off_digits + 2'd1;
            end
            return;
        end
        if (!nib_pending) begin
            hi_nib = d[3:0];
            nib_pending = 1'b1;
            return;
        end
        nib_pending = 1'b0;
        b = {hi_nib, d[3:0]};
        sum_acc = sum_acc + b;
        case (pstate)
            GET_COUNT: begin
                rec_len = b;
                pstate = GET_OFFSET;
                off_digits = '0;
            end
            GET_TYPE: begin
                rec_type = b;
                pstate = (rec_len != 0) ? GET_DATA : GET_SUM;
            end
            GET_DATA: begin
                if (data_count == 8'd0)
                    seg_bytes[15:8] = b;
                else if (data_count == 8'd1)
                    seg_bytes[7:0] = b;
                if (rec_type == hrp_pkg::REC_DATA) begin
                    has = 1'b1;
                    w.kind = hrp_pkg::KIND_DATA;
                    w.addr = {1'b0, seg_base, 4'h0} + ADDR_W'(rec_off) + ADDR_W'(data_count);
                    w.value = b;
                end
                data_count = data_count + 8'd1;
                if (data_count == rec_len)
                    pstate = GET_SUM;
            end
            GET_SUM: begin
                has = 1'b1;
                // checksum is judged before the type
                if (sum_acc != 8'd0) begin
                    halted = 1'b1;
                    w.kind = hrp_pkg::KIND_ERROR;
                    w.err = hrp_pkg::ERR_CHECKSUM;
                end else begin
                    pstate = AWAIT_COLON;
                    if (rec_type == hrp_pkg::REC_DATA) begin
                        w.kind = hrp_pkg::KIND_OK;
                    end else if (rec_type == hrp_pkg::REC_EOF) begin
                        halted = 1'b1;
                        w.kind = hrp_pkg::KIND_EOF;
                    end else if (rec_type == hrp_pkg::REC_SEGMENT) begin
                        seg_base = seg_bytes;
                        w.kind = hrp_pkg::KIND_OK;
                    end else begin
                        halted = 1'b1;
                        w.kind = hrp_pkg::KIND_ERROR;
                        w.err = hrp_pkg::ERR_TYPE;
                    end
                end
            end
            default: pstate = AWAIT_COLON;
        endcase
    endfunction

    task automatic report_mismatch(input string msg);
        mismatch_count++;
        $display("%0t ns: mismatch: %s", $time, msg);
    endtask

    // Predict on every accepted char, check every accepted result word
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (char_ch.valid && char_ch.ready) begin
                parse_char(char_ch.char_in, parsed_has, parsed_word);
                if (row_check == CHK_WORD)
                    expected_words.push_back(row_word);
                else if (row_check == CHK_PREDICT && parsed_has)
                    expected_words.push_back(parsed_word);
            end
            if (result_ch.valid && result_ch.ready) begin
                if (expected_words.size() == 0) begin
                    report_mismatch($sformatf("kind %0d word with nothing expected",
                                              result_ch.kind));
                end else begin
                    want = expected_words.pop_front();
                    if (result_ch.kind !== want.kind)
                        report_mismatch($sformatf("kind %0d, expected %0d",
                                                  result_ch.kind, want.kind));
                    if (result_ch.byte_address !== want.addr)
                        report_mismatch($sformatf("address %0h, expected %0h",
                                                  result_ch.byte_address, want.addr));
                    if (result_ch.byte_value !== want.value)
                        report_mismatch($sformatf("value %0h, expected %0h",
                                                  result_ch.byte_value, want.value));
                    if (result_ch.error_code !== want.err)
                        report_mismatch($sformatf("error code %0d, expected %0d",
                                                  result_ch.error_code, want.err));
                end
            end
        end
    end

    // Mostly no gap, often a short one, now and then a long one
    function automatic int unsigned idle_len();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic logic [7:0] blank_char();
        logic [7:0] r;
        r = 8'($urandom_range(0, 5));
        return (r == 8'd5) ? 8'h20 : 8'h09 + r;
    endfunction

    // Hex digit in random case
    function automatic logic [7:0] hex_char(input logic [3:0] n);
        if (n < 4'd10)
            return 8'h30 + 8'(n);
        return ($urandom_range(0, 1) ? 8'h61 : 8'h41) + 8'(n) - 8'd10;
    endfunction

    // Neither whitespace nor hex digit; colon only when allowed
    function automatic logic [7:0] stray_char(input bit colon_ok);
        logic [7:0] c;
        if ($urandom_range(0, 3) == 0)
            return $urandom_range(0, 1) ? 8'hFF : 8'h00;
        do begin
            c = 8'($urandom);
        end while (c == 8'h20 || (c >= 8'h09 && c <= 8'h0D)
                   || (c >= 8'h30 && c <= 8'h39) || (c >= 8'h41 && c <= 8'h46)
                   || (c >= 8'h61 && c <= 8'h66)
                   || (!colon_ok && c == hrp_pkg::CHAR_COLON));
        return c;
    endfunction

    function automatic logic [7:0] data_byte();
        int unsigned r;
        r = $urandom_range(0, 15);
        if (r == 0)
            return 8'h00;
        if (r == 1)
            return 8'hFF;
        return 8'($urandom);
    endfunction

    // Whitespace may land between any two chars
    function automatic void push_char(input logic [7:0] c);
        if ($urandom_range(0, 9) == 0)
            char_stream.push_back(blank_char());
        char_stream.push_back(c);
    endfunction

    function automatic void push_byte(input logic [7:0] b, inout logic [7:0] sum);
        push_char(hex_char(b[7:4]));
        push_char(hex_char(b[3:0]));
        sum = sum + b;
    endfunction

    // lead gives the first two data bytes; the rest are random
    function automatic void push_record(input logic [7:0] len, input logic [15:0] off,
                                        input logic [7:0] typ, input logic [15:0] lead,
                                        input bit bad_sum);
        logic [7:0] sum;
        logic [7:0] b;
        int i;
        sum = '0;
        push_char(hrp_pkg::CHAR_COLON);
        push_byte(len, sum);
        push_byte(off[15:8], sum);
        push_byte(off[7:0], sum);
        push_byte(typ, sum);
        for (i = 0; i < int'(len); i++) begin
            b = (i == 0) ? lead[15:8] : (i == 1) ? lead[7:0] : data_byte();
            push_byte(b, sum);
        end
        b = 8'(8'd0 - sum);
        if (bad_sum)
            b = b ^ 8'($urandom_range(1, 255));
        push_byte(b, sum);
    endfunction

    // Offer one char after an optional gap and wait until it is taken
    task automatic send_char(input logic [7:0] c, input t_row_check chk,
                             input t_result w, input int unsigned gap);
        if (gap != 0) begin
            @(negedge i_clk);
            char_ch.valid <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        char_ch.valid <= 1'b1;
        char_ch.char_in <= c;
        row_check = chk;
        row_word = w;
        do @(posedge i_clk); while (!char_ch.ready);
    endtask

    // Result sink: random stalls, ready stretches, one long hold on request
    initial begin
        int unsigned n;
        logic rdy;
        result_ch.ready = 1'b0;
        @(negedge i_clk);
        forever begin
            if (hold_request) begin
                hold_request = 1'b0;
                rdy = 1'b0;
                n = LONG_HOLD;
            end else if ($urandom_range(0, 31) == 0) begin
                rdy = 1'b1;
                n = $urandom_range(30, 80);
            end else begin
                n = idle_len();
                rdy = (n == 0);
                if (rdy)
                    n = $urandom_range(1, 6);
            end
            result_ch.ready <= rdy;
            repeat (n) @(negedge i_clk);
        end
    end

    // Char source
    initial begin
        int unsigned idx;
        int unsigned gap;
        int unsigned calm_left;
        int unsigned r;
        logic [7:0] len;
        logic [15:0] off;
        t_ending ending;

        char_ch.valid = 1'b0;
        char_ch.char_in = 8'h00;
        calm_left = 0;

        // top segment base with the longest record at the top offset
        push_record(8'd2, 16'($urandom), hrp_pkg::REC_SEGMENT, 16'hFFFF, 1'b0);
        push_record(8'd255, 16'hFFFF, hrp_pkg::REC_DATA, 16'($urandom), 1'b0);
        push_record(8'd2, 16'($urandom), hrp_pkg::REC_SEGMENT, 16'($urandom), 1'b0);

        // well-formed data and segment records
        while (char_stream.size() < RANDOM_CHARS) begin
            r = $urandom_range(0, 99);
            if (r < 18) begin
                push_record(8'($urandom_range(0, 4)), 16'($urandom), hrp_pkg::REC_SEGMENT,
                            {data_byte(), data_byte()}, 1'b0);
            end else begin
                len = (r < 22) ? 8'd0 :
                      (r == 99) ? 8'($urandom_range(16, 255)) : 8'($urandom_range(1, 8));
                off = (r < 26) ? 16'hFFFF : (r < 30) ? 16'h0000 : 16'($urandom);
                push_record(len, off, hrp_pkg::REC_DATA, {data_byte(), data_byte()}, 1'b0);
            end
        end

        // one terminating event, then chars that must all be ignored
        ending = t_ending'($urandom_range(0, 4));
        case (ending)
            END_EOF: begin
                push_record(8'($urandom_range(0, 2)), 16'($urandom), hrp_pkg::REC_EOF,
                            16'($urandom), 1'b0);
            end
            END_BAD_START: begin
                char_stream.push_back(stray_char(1'b0));
            end
            END_NOT_HEX: begin
                char_stream.push_back(hrp_pkg::CHAR_COLON);
                repeat ($urandom_range(0, 12)) char_stream.push_back(hex_char(4'($urandom)));
                char_stream.push_back(stray_char(1'b1));
            end
            END_BAD_SUM: begin
                push_record(8'($urandom_range(0, 6)), 16'($urandom), 8'($urandom),
                            16'($urandom), 1'b1);
            end
            default: begin
                push_record(8'($urandom_range(0, 3)), 16'($urandom),
                            8'($urandom_range(3, 255)), 16'($urandom), 1'b0);
            end
        endcase
        push_record(8'd1, 16'($urandom), hrp_pkg::REC_DATA, 16'($urandom), 1'b0);
        repeat (24) char_stream.push_back(8'($urandom));

        while (!i_rst_n) @(posedge i_clk);

        foreach (directed_rows[k])
            send_char(directed_rows[k].ch, directed_rows[k].check, directed_rows[k].w,
                      idle_len());

        for (idx = 0; idx < char_stream.size(); idx++) begin
            if (idx == HOLD_AT)
                hold_request = 1'b1;
            // pause until every outstanding word has drained
            if (idx == DRAIN_AT) begin
                @(negedge i_clk);
                char_ch.valid <= 1'b0;
                while (expected_words.size() != 0) @(posedge i_clk);
            end
            if (calm_left != 0) begin
                calm_left--;
                gap = 0;
            end else begin
                gap = idle_len();
                if ($urandom_range(0, 199) == 0)
                    calm_left = 60;
            end
            send_char(char_stream[idx], CHK_PREDICT, NO_WORD, gap);
        end

        @(negedge i_clk);
        char_ch.valid <= 1'b0;
        while (expected_words.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);

        if (mismatch_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
